/* design/tfc_pkg.sv */
// Shared constants, types and the CRC-16-CCITT byte step for the TLV frame checker.
package tfc_pkg;

	// Fixed packet layout
	localparam int HEADER_BYTES = 8;
	localparam int CRC_BYTES    = 2;
	localparam logic [15:0] MIN_FLOOR = 16'(HEADER_BYTES + CRC_BYTES);

	// CRC-16-CCITT, MSB first, no final xor
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Counter saturation value
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// Result queue
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// Stream widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_FIELD_W = 16 + 16 + 16 + 3 + 16 + 16 + 16;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC_WORD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BYTES  = 1'b1;

	// Result kinds
	localparam logic KIND_CHUNK  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_TOO_SHORT    = 3'd1,
		ST_BAD_MAGIC    = 3'd2,
		ST_LEN_MISMATCH = 3'd3,
		ST_TRUNCATED    = 3'd4,
		ST_BAD_CRC      = 3'd5
	} status_t;

	// Chunk walker phase, one-hot
	typedef enum logic [4:0] {
		PH_TYPE_HI = 5'b00001,
		PH_TYPE_LO = 5'b00010,
		PH_LEN_HI  = 5'b00100,
		PH_LEN_LO  = 5'b01000,
		PH_VALUE   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] chunk_type;
		logic [15:0] chunk_length;
		logic [15:0] chunk_offset;
		status_t     status;
		logic [15:0] seq_num;
		logic [15:0] received_crc;
		logic [15:0] computed_crc;
		logic        last_of_run;
	} res_t;

	// Advance the CRC by one byte, eight bit steps
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* design/tlv_frame_checker.sv */
// Top level of the TLV frame checker: header capture, chunk walk, CRC and result queue.
//
// Usage: packet bytes enter on the s_axis channel, one byte per transfer, with
// s_axis_tlast on the final byte of a packet. Results leave on m_axis: a chunk
// descriptor (tuser = 0) each time a chunk's value completes, and a packet
// status (tuser = 1) after the last byte. m_axis_tlast marks the final result
// caused by one input byte. Descriptors are speculative until the status of
// their packet arrives. The cfg channel writes the magic word (index 0) and
// the minimum packet size (index 1); the user must do so only while the block
// is idle, as the block does not enforce it. cfg_ready is always high.
// Each result enters the registered result queue when its byte is accepted.
// Throughput: one byte per cycle; the header, chunk and CRC logic all finish
// in the accept cycle. A byte that causes two results occupies two queue
// slots, and s_axis_tready drops while fewer than two of the four slots of
// the result queue are free, so a stalled receiver holds the input back
// once three or more results wait in the queue.
// Reset: arst_n clears the packet state, the queue and the registers
// (magic word 0, minimum size 10).
module tlv_frame_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	// cfg channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data,
	// input bytes
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [tfc_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // [7:0] byte_value
	input  logic                           s_axis_tlast,  // is_last
	// results
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [15:0] chunk_type, [31:16] chunk_length, [47:32] chunk_offset,
	// [50:48] status, [66:51] seq_num, [82:67] received_crc,
	// [98:83] computed_crc, [103:99] zero
	output logic [tfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tuser,  // kind
	output logic                            m_axis_tlast   // last_of_run
);

	// Configuration registers
	logic [31:0] magic_word_q;
	logic [15:0] min_bytes_q;

	// Packet state
	logic [15:0]      byte_cnt_q;
	logic [31:0]      magic_shift_q;
	logic [15:0]      seq_q;
	logic [15:0]      total_len_q;
	logic [15:0]      crc_q;
	logic [15:0]      trailer_crc_q;
	tfc_pkg::phase_t  phase_q;
	logic [15:0]      chunk_type_q;
	logic [15:0]      chunk_len_q;
	logic [15:0]      val_rem_q;
	logic [15:0]      chunk_start_q;
	logic             trunc_q;

	logic [15:0]      byte_cnt_nx;
	logic [31:0]      magic_shift_nx;
	logic [15:0]      seq_nx;
	logic [15:0]      total_len_nx;
	logic [15:0]      crc_nx;
	logic [15:0]      trailer_crc_nx;
	tfc_pkg::phase_t  phase_nx;
	logic [15:0]      chunk_type_nx;
	logic [15:0]      chunk_len_nx;
	logic [15:0]      val_rem_nx;
	logic [15:0]      chunk_start_nx;
	logic             trunc_nx;

	// Result queue
	tfc_pkg::res_t                  fifo_q [tfc_pkg::OUT_DEPTH];
	logic [tfc_pkg::OUT_PTR_W-1:0]  wr_ptr_q;
	logic [tfc_pkg::OUT_PTR_W-1:0]  rd_ptr_q;
	logic [tfc_pkg::OUT_CNT_W-1:0]  fifo_cnt_q;

	logic           in_xfer;
	logic           out_xfer;
	logic [7:0]     in_byte;
	logic           in_header;
	logic           in_payload;
	logic           in_trailer;
	logic [16:0]    pos_plus_crc;
	logic [15:0]    pos_plus_one;
	logic [15:0]    rem_dec;
	logic [15:0]    min_eff;
	logic [15:0]    crc_step;
	logic           chunk_emit;
	logic           stat_emit;
	tfc_pkg::status_t status_val;
	tfc_pkg::res_t  chunk_res;
	tfc_pkg::res_t  stat_res;
	tfc_pkg::res_t  head_res;
	logic [1:0]     n_push;

	assign in_byte  = s_axis_tdata;
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// Hold the input while fewer than two queue slots are free
	assign s_axis_tready = fifo_cnt_q <= tfc_pkg::OUT_CNT_W'(tfc_pkg::OUT_DEPTH - 2);
	assign cfg_ready     = 1'b1;

	// Classify the current byte position
	assign pos_plus_crc = {1'b0, byte_cnt_q} + 17'(tfc_pkg::CRC_BYTES);
	assign pos_plus_one = byte_cnt_q + 16'd1;
	assign in_header    = byte_cnt_q < 16'(tfc_pkg::HEADER_BYTES);
	assign in_payload   = !in_header && (pos_plus_crc < {1'b0, total_len_q});
	assign in_trailer   = !in_header && !in_payload && (byte_cnt_q < total_len_q);
	assign rem_dec      = (val_rem_q != 16'd0) ? val_rem_q - 16'd1 : 16'd0;
	assign crc_step     = tfc_pkg::crc16_byte(crc_q, in_byte);
	assign min_eff      = (min_bytes_q < tfc_pkg::MIN_FLOOR) ? tfc_pkg::MIN_FLOOR
		: min_bytes_q;

	// Advance the packet state for one byte
	always_comb begin
		byte_cnt_nx    = (byte_cnt_q != tfc_pkg::COUNT_MAX) ? pos_plus_one : byte_cnt_q;
		magic_shift_nx = magic_shift_q;
		seq_nx         = seq_q;
		total_len_nx   = total_len_q;
		crc_nx         = crc_q;
		trailer_crc_nx = trailer_crc_q;
		phase_nx       = phase_q;
		chunk_type_nx  = chunk_type_q;
		chunk_len_nx   = chunk_len_q;
		val_rem_nx     = val_rem_q;
		chunk_start_nx = chunk_start_q;
		trunc_nx       = trunc_q;
		chunk_emit     = 1'b0;

		// Header field capture
		if (byte_cnt_q < 16'd4) begin
			magic_shift_nx = {magic_shift_q[23:0], in_byte};
		end else if (byte_cnt_q < 16'd6) begin
			seq_nx = {seq_q[7:0], in_byte};
		end else if (in_header) begin
			total_len_nx = {total_len_q[7:0], in_byte};
		end

		if (in_header) begin
			crc_nx = crc_step;
		end else if (in_payload) begin
			crc_nx = crc_step;
			// Walk the chunk fields
			unique case (phase_q)
				tfc_pkg::PH_TYPE_HI: begin
					chunk_type_nx = {in_byte, 8'h00};
					phase_nx      = tfc_pkg::PH_TYPE_LO;
				end
				tfc_pkg::PH_TYPE_LO: begin
					chunk_type_nx = {chunk_type_q[15:8], in_byte};
					phase_nx      = tfc_pkg::PH_LEN_HI;
				end
				tfc_pkg::PH_LEN_HI: begin
					chunk_len_nx = {in_byte, 8'h00};
					phase_nx     = tfc_pkg::PH_LEN_LO;
				end
				tfc_pkg::PH_LEN_LO: begin
					chunk_len_nx   = {chunk_len_q[15:8], in_byte};
					chunk_start_nx = pos_plus_one;
					if (chunk_len_nx == 16'd0) begin
						chunk_emit = 1'b1;
						phase_nx   = tfc_pkg::PH_TYPE_HI;
					end else begin
						val_rem_nx = chunk_len_nx;
						phase_nx   = tfc_pkg::PH_VALUE;
					end
				end
				tfc_pkg::PH_VALUE: begin
					val_rem_nx = rem_dec;
					if (rem_dec == 16'd0) begin
						chunk_emit = 1'b1;
						phase_nx   = tfc_pkg::PH_TYPE_HI;
					end
				end
				default: begin
					phase_nx = tfc_pkg::PH_TYPE_HI;
				end
			endcase
		end else if (in_trailer) begin
			// Trailer CRC, big-endian
			if (pos_plus_crc == {1'b0, total_len_q}) begin
				trailer_crc_nx = {in_byte, 8'h00};
				if (phase_q != tfc_pkg::PH_TYPE_HI) begin
					trunc_nx = 1'b1;
				end
			end else begin
				trailer_crc_nx = {trailer_crc_q[15:8], in_byte};
			end
		end
	end

	// Decide the packet status from the state after this byte
	always_comb begin
		if (byte_cnt_nx < min_eff) begin
			status_val = tfc_pkg::ST_TOO_SHORT;
		end else if (magic_shift_nx != magic_word_q) begin
			status_val = tfc_pkg::ST_BAD_MAGIC;
		end else if (total_len_nx < min_eff || total_len_nx > byte_cnt_nx) begin
			status_val = tfc_pkg::ST_LEN_MISMATCH;
		end else if (trunc_nx) begin
			status_val = tfc_pkg::ST_TRUNCATED;
		end else if (crc_nx != trailer_crc_nx) begin
			status_val = tfc_pkg::ST_BAD_CRC;
		end else begin
			status_val = tfc_pkg::ST_OK;
		end
	end

	assign stat_emit = s_axis_tlast;

	// Build the two possible results
	always_comb begin
		chunk_res              = '0;
		chunk_res.kind         = tfc_pkg::KIND_CHUNK;
		chunk_res.chunk_type   = chunk_type_nx;
		chunk_res.chunk_length = chunk_len_nx;
		chunk_res.chunk_offset = chunk_start_nx;
		chunk_res.status       = tfc_pkg::ST_OK;
		chunk_res.last_of_run  = !stat_emit;

		stat_res              = '0;
		stat_res.kind         = tfc_pkg::KIND_STATUS;
		stat_res.status       = status_val;
		stat_res.seq_num      = seq_nx;
		stat_res.received_crc = trailer_crc_nx;
		stat_res.computed_crc = crc_nx;
		stat_res.last_of_run  = 1'b1;
	end

	assign n_push = in_xfer ? (2'(chunk_emit) + 2'(stat_emit)) : 2'd0;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q <= '0;
			min_bytes_q  <= tfc_pkg::MIN_FLOOR;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tfc_pkg::REG_MAGIC_WORD: magic_word_q <= cfg_data;
				tfc_pkg::REG_MIN_BYTES:  min_bytes_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Update packet state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q    <= '0;
			magic_shift_q <= '0;
			seq_q         <= '0;
			total_len_q   <= '0;
			crc_q         <= tfc_pkg::CRC_INIT;
			trailer_crc_q <= '0;
			phase_q       <= tfc_pkg::PH_TYPE_HI;
			chunk_type_q  <= '0;
			chunk_len_q   <= '0;
			val_rem_q     <= '0;
			chunk_start_q <= '0;
			trunc_q       <= 1'b0;
		end else if (in_xfer) begin
			if (s_axis_tlast) begin
				byte_cnt_q    <= '0;
				magic_shift_q <= '0;
				seq_q         <= '0;
				total_len_q   <= '0;
				crc_q         <= tfc_pkg::CRC_INIT;
				trailer_crc_q <= '0;
				phase_q       <= tfc_pkg::PH_TYPE_HI;
				chunk_type_q  <= '0;
				chunk_len_q   <= '0;
				val_rem_q     <= '0;
				chunk_start_q <= '0;
				trunc_q       <= 1'b0;
			end else begin
				byte_cnt_q    <= byte_cnt_nx;
				magic_shift_q <= magic_shift_nx;
				seq_q         <= seq_nx;
				total_len_q   <= total_len_nx;
				crc_q         <= crc_nx;
				trailer_crc_q <= trailer_crc_nx;
				phase_q       <= phase_nx;
				chunk_type_q  <= chunk_type_nx;
				chunk_len_q   <= chunk_len_nx;
				val_rem_q     <= val_rem_nx;
				chunk_start_q <= chunk_start_nx;
				trunc_q       <= trunc_nx;
			end
		end
	end

	// Write results into the queue, chunk descriptor first
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= chunk_emit ? chunk_res : stat_res;
		end
		if (n_push == 2'd2) begin
			fifo_q[wr_ptr_q + 1'b1] <= stat_res;
		end
	end

	// Advance queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			wr_ptr_q   <= wr_ptr_q + tfc_pkg::OUT_PTR_W'(n_push);
			rd_ptr_q   <= rd_ptr_q + tfc_pkg::OUT_PTR_W'(out_xfer);
			fifo_cnt_q <= fifo_cnt_q + tfc_pkg::OUT_CNT_W'(n_push)
				- tfc_pkg::OUT_CNT_W'(out_xfer);
		end
	end

	// Drive the result channel from the queue head
	assign head_res      = fifo_q[rd_ptr_q];
	assign m_axis_tvalid = fifo_cnt_q != '0;
	assign m_axis_tuser  = head_res.kind;
	assign m_axis_tlast  = head_res.last_of_run;
	assign m_axis_tdata  = {
		(tfc_pkg::OUT_TDATA_W - tfc_pkg::OUT_FIELD_W)'(0),
		head_res.computed_crc,
		head_res.received_crc,
		head_res.seq_num,
		head_res.status,
		head_res.chunk_offset,
		head_res.chunk_length,
		head_res.chunk_type
	};

	// Queue never overfills
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= tfc_pkg::OUT_CNT_W'(tfc_pkg::OUT_DEPTH))
		else $error("result queue overfilled");

	// A status result always closes its run
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == tfc_pkg::KIND_STATUS) |-> m_axis_tlast)
		else $error("status result without tlast");

	// A chunk descriptor carries no status
	a_chunk_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == tfc_pkg::KIND_CHUNK) |->
		m_axis_tdata[50:48] == tfc_pkg::ST_OK)
		else $error("chunk descriptor with nonzero status");

	// Packet state restarts after the last byte
	a_packet_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_axis_tlast) |=> (byte_cnt_q == '0 && phase_q == tfc_pkg::PH_TYPE_HI
		&& crc_q == tfc_pkg::CRC_INIT))
		else $error("packet state not cleared after last byte");

endmodule

/* tb/testbench.sv */
// Testbench for the TLV frame checker: frame stimulus, byte-level predictor and result scoreboard.
module testbench;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 8;
	localparam int LIMIT_CYCLES  = 2_000_000;
	localparam int REPORT_LIMIT  = 10;
	localparam int HDR_LEN       = 8;
	localparam int TRAILER_LEN   = 2;
	localparam logic [15:0] FLOOR_LEN  = 16'(HDR_LEN + TRAILER_LEN);
	localparam logic [15:0] CCITT_SEED = 16'hFFFF;
	localparam logic [15:0] CCITT_POLY = 16'h1021;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [tfc_pkg::CFG_IDX_W-1:0]   cfg_index = tfc_pkg::REG_MAGIC_WORD;
	logic [31:0]                     cfg_data = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [tfc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;  // [7:0] byte_value
	logic                            s_axis_tlast = 1'b0;  // is_last
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	// [15:0] chunk_type, [31:16] chunk_length, [47:32] chunk_offset, [50:48] status,
	// [66:51] seq_num, [82:67] received_crc, [98:83] computed_crc
	logic [tfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                            m_axis_tuser;  // kind
	logic                            m_axis_tlast;  // last_of_run

	// Register copies and per-frame parser state
	logic [31:0] cur_magic = '0;
	logic [15:0] cur_min = 16'd10;
	logic [15:0] rx_count, rx_seq, rx_total, rx_crc, rx_trailer;
	logic [31:0] rx_magic;
	tfc_pkg::phase_t walk_phase;
	logic [15:0] walk_type, walk_len, walk_left, walk_start;
	logic        walk_open;

	tfc_pkg::res_t pending_results[$];
	logic [7:0]  frame_bytes[$];
	int          fail_count = 0;
	int          bytes_accepted = 0;
	int          src_idle = 14;
	int          sink_idle = 46;

	tlv_frame_checker i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Stall the result stream at random
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_idle);
	end

	// Advance CRC-16-CCITT by one byte, MSB first
	function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CCITT_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// Append one expected result and one frame byte
	task automatic expect_result(input tfc_pkg::res_t r);
		pending_results = {pending_results, r};
	endtask

	task automatic put_byte(input logic [7:0] b);
		frame_bytes = {frame_bytes, b};
	endtask

	task automatic clear_frame_state();
		rx_count = '0;
		rx_magic = '0;
		rx_seq = '0;
		rx_total = '0;
		rx_crc = CCITT_SEED;
		rx_trailer = '0;
		walk_phase = tfc_pkg::PH_TYPE_HI;
		walk_type = '0;
		walk_len = '0;
		walk_left = '0;
		walk_start = '0;
		walk_open = 1'b0;
	endtask

	task automatic push_chunk(input logic [15:0] len);
		tfc_pkg::res_t r;
		r = '0;
		r.kind = tfc_pkg::KIND_CHUNK;
		r.chunk_type = walk_type;
		r.chunk_length = len;
		r.chunk_offset = walk_start;
		r.status = tfc_pkg::ST_OK;
		expect_result(r);
	endtask

	// Parse one accepted byte and queue the results it must cause
	task automatic parse_byte(input logic [7:0] b, input logic last);
		int unsigned      pos, tl;
		int               made;
		logic [15:0]      min_len;
		tfc_pkg::res_t    r;
		tfc_pkg::status_t st;
		pos = rx_count;
		tl = rx_total;
		made = pending_results.size();

		// Capture header fields
		if (pos < 4) begin
			rx_magic = {rx_magic[23:0], b};
		end else if (pos < 6) begin
			rx_seq = {rx_seq[7:0], b};
		end else if (pos < HDR_LEN) begin
			rx_total = {rx_total[7:0], b};
		end

		// Walk chunks in the payload, then take the trailer
		if (pos < HDR_LEN) begin
			rx_crc = crc_ccitt_step(rx_crc, b);
		end else if (pos + TRAILER_LEN < tl) begin
			rx_crc = crc_ccitt_step(rx_crc, b);
			case (walk_phase)
				tfc_pkg::PH_TYPE_HI: begin
					walk_type = {b, 8'h00};
					walk_phase = tfc_pkg::PH_TYPE_LO;
				end
				tfc_pkg::PH_TYPE_LO: begin
					walk_type[7:0] = b;
					walk_phase = tfc_pkg::PH_LEN_HI;
				end
				tfc_pkg::PH_LEN_HI: begin
					walk_len = {b, 8'h00};
					walk_phase = tfc_pkg::PH_LEN_LO;
				end
				tfc_pkg::PH_LEN_LO: begin
					walk_len[7:0] = b;
					walk_start = 16'(pos + 1);
					if (walk_len == 0) begin
						push_chunk(16'd0);
						walk_phase = tfc_pkg::PH_TYPE_HI;
					end else begin
						walk_left = walk_len;
						walk_phase = tfc_pkg::PH_VALUE;
					end
				end
				default: begin
					if (walk_left > 0) walk_left--;
					if (walk_left == 0) begin
						push_chunk(walk_len);
						walk_phase = tfc_pkg::PH_TYPE_HI;
					end
				end
			endcase
		end else if (pos < tl) begin
			if (pos + TRAILER_LEN == tl) begin
				rx_trailer = {b, 8'h00};
				if (walk_phase != tfc_pkg::PH_TYPE_HI) walk_open = 1'b1;
			end else begin
				rx_trailer[7:0] = b;
			end
		end

		if (rx_count != 16'hFFFF) rx_count++;

		// Close the frame with its status
		if (last) begin
			min_len = (cur_min < FLOOR_LEN) ? FLOOR_LEN : cur_min;
			if (rx_count < min_len) st = tfc_pkg::ST_TOO_SHORT;
			else if (rx_magic != cur_magic) st = tfc_pkg::ST_BAD_MAGIC;
			else if (rx_total < min_len || rx_total > rx_count) st = tfc_pkg::ST_LEN_MISMATCH;
			else if (walk_open) st = tfc_pkg::ST_TRUNCATED;
			else if (rx_crc != rx_trailer) st = tfc_pkg::ST_BAD_CRC;
			else st = tfc_pkg::ST_OK;
			r = '0;
			r.kind = tfc_pkg::KIND_STATUS;
			r.status = st;
			r.seq_num = rx_seq;
			r.received_crc = rx_trailer;
			r.computed_crc = rx_crc;
			expect_result(r);
			clear_frame_state();
		end

		if (pending_results.size() > made)
			pending_results[pending_results.size() - 1].last_of_run = 1'b1;
	endtask

	// Score each result transfer against the oldest expectation
	always @(posedge clk) begin
		tfc_pkg::res_t seen, want;
		if (m_axis_tvalid && m_axis_tready) begin
			seen.kind = m_axis_tuser;
			seen.chunk_type = m_axis_tdata[15:0];
			seen.chunk_length = m_axis_tdata[31:16];
			seen.chunk_offset = m_axis_tdata[47:32];
			seen.status = tfc_pkg::status_t'(m_axis_tdata[50:48]);
			seen.seq_num = m_axis_tdata[66:51];
			seen.received_crc = m_axis_tdata[82:67];
			seen.computed_crc = m_axis_tdata[98:83];
			seen.last_of_run = m_axis_tlast;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected result: kind %0d tdata %h last %0d",
						m_axis_tuser, m_axis_tdata, m_axis_tlast);
			end else begin
				want = pending_results.pop_front();
				if (seen !== want) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT) begin
						$display("exp: k %0d typ %h len %h off %h st %0d seq %h rx %h crc %h l %0d",
							want.kind, want.chunk_type, want.chunk_length,
							want.chunk_offset, want.status, want.seq_num,
							want.received_crc, want.computed_crc, want.last_of_run);
						$display("act: k %0d typ %h len %h off %h st %0d seq %h rx %h crc %h l %0d",
							seen.kind, seen.chunk_type, seen.chunk_length,
							seen.chunk_offset, seen.status, seen.seq_num,
							seen.received_crc, seen.computed_crc, seen.last_of_run);
					end
				end
			end
		end
	end

	// Offer one byte, with random gaps ahead of it, and hold it until the transfer
	task automatic send_byte(input logic [7:0] value, input logic last);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		parse_byte(value, last);
		bytes_accepted++;
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	// Drop valid and let every expected result drain
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offer one register write and hold it until the transfer
	task automatic write_reg(input logic [tfc_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == tfc_pkg::REG_MAGIC_WORD) cur_magic = value;
		else cur_min = value[15:0];
	endtask

	task automatic set_config(input logic [31:0] magic, input logic [31:0] min_word);
		wait_idle();
		write_reg(tfc_pkg::REG_MAGIC_WORD, magic);
		write_reg(tfc_pkg::REG_MIN_BYTES, min_word);
		cfg_valid <= 1'b0;
	endtask

	// Frame builders: header with a blank total length, chunks, then total and CRC
	task automatic frame_start(input logic [31:0] magic, input logic [15:0] seq);
		frame_bytes.delete();
		for (int i = 3; i >= 0; i--) put_byte(magic[8*i +: 8]);
		put_byte(seq[15:8]);
		put_byte(seq[7:0]);
		put_byte(8'h00);
		put_byte(8'h00);
	endtask

	task automatic add_chunk(input logic [15:0] kind_code, input logic [15:0] len);
		put_byte(kind_code[15:8]);
		put_byte(kind_code[7:0]);
		put_byte(len[15:8]);
		put_byte(len[7:0]);
		repeat (len) put_byte(8'($urandom));
	endtask

	// Chunk cut off by the trailer: keep only part of its header or value
	task automatic add_open_chunk(input logic [15:0] kind_code, input logic [15:0] len,
		input int keep, input int have);
		logic [31:0] head;
		head = {kind_code, len};
		for (int i = 0; i < keep; i++) put_byte(head[31 - 8*i -: 8]);
		if (keep == 4) repeat (have) put_byte(8'($urandom));
	endtask

	task automatic frame_close();
		logic [15:0] total, crc;
		total = 16'(frame_bytes.size() + TRAILER_LEN);
		frame_bytes[6] = total[15:8];
		frame_bytes[7] = total[7:0];
		crc = CCITT_SEED;
		foreach (frame_bytes[i]) crc = crc_ccitt_step(crc, frame_bytes[i]);
		put_byte(crc[15:8]);
		put_byte(crc[7:0]);
	endtask

	// Mostly well-formed frames, plus damaged frames and noise
	task automatic build_random_frame();
		int          mode;
		int unsigned len;
		logic [15:0] min_len;
		mode = $urandom_range(99);
		min_len = (cur_min < FLOOR_LEN) ? FLOOR_LEN : cur_min;
		if (mode >= 92) begin
			frame_bytes.delete();
			repeat ($urandom_range(1, 24)) put_byte(8'($urandom));
		end else begin
			frame_start((mode >= 76 && mode < 82) ? $urandom : cur_magic, 16'($urandom));
			repeat ($urandom_range(0, 4)) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
				add_chunk(16'($urandom), 16'(len));
			end
			while (frame_bytes.size() + TRAILER_LEN < min_len)
				add_chunk(16'($urandom), 16'($urandom_range(0, 12)));
			if (mode >= 60 && mode < 68) begin
				len = $urandom_range(1, 40);
				add_open_chunk(16'($urandom), 16'(len), $urandom_range(1, 4),
					$urandom_range(0, len - 1));
			end
			frame_close();
			if (mode >= 50 && mode < 60) begin
				repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
			end else if (mode >= 68 && mode < 76) begin
				len = $urandom_range(frame_bytes.size() - 1);
				frame_bytes[len] = frame_bytes[len] ^ (8'h01 << $urandom_range(7));
			end else if (mode >= 82 && mode < 87) begin
				frame_bytes[6] = $urandom_range(1) ? 8'h00 : 8'($urandom);
				frame_bytes[7] = 8'($urandom);
			end else if (mode >= 87) begin
				repeat ($urandom_range(1, 4)) void'(frame_bytes.pop_back());
			end
		end
	endtask

	// Every status under the reset registers, with field extremes
	task automatic test_status_order();
		// clean frame: zero-length chunk of the top type, then a short chunk
		frame_start(32'h0, 16'hFFFF);
		add_chunk(16'hFFFF, 16'd0);
		add_chunk(16'h0000, 16'd3);
		frame_close();
		send_frame();
		// too short: one byte, then nine bytes
		frame_bytes = {8'hFF};
		send_frame();
		frame_start(32'h0, 16'h0000);
		put_byte(8'h00);
		send_frame();
		// wrong magic
		frame_start(32'hFFFF_FFFF, 16'h1234);
		add_chunk(16'h00FF, 16'd1);
		frame_close();
		send_frame();
		// total length runs past the end of the frame
		frame_start(32'h0, 16'h0001);
		add_chunk(16'hA5A5, 16'd2);
		frame_close();
		frame_bytes[7] = frame_bytes[7] + 8'd1;
		send_frame();
		// total length below the floor: only header bytes feed the CRC
		frame_start(32'h0, 16'h0002);
		frame_bytes[7] = 8'h05;
		put_byte(8'h3C);
		put_byte(8'hC3);
		send_frame();
		// chunk of the largest length still open at the trailer
		frame_start(32'h0, 16'h0003);
		add_open_chunk(16'h7E7E, 16'hFFFF, 4, 2);
		frame_close();
		send_frame();
		// damaged trailer
		frame_start(32'h0, 16'h0004);
		add_chunk(16'h0001, 16'd2);
		frame_close();
		frame_bytes[frame_bytes.size() - 1] = frame_bytes[frame_bytes.size() - 1] ^ 8'h01;
		send_frame();
		// bytes past the total length are ignored
		frame_start(32'h0, 16'h0005);
		add_chunk(16'h0002, 16'd1);
		frame_close();
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(8'h5A);
		send_frame();
	endtask

	// Minimum below the floor, then a minimum above it
	task automatic test_config_limits();
		set_config(32'hFFFF_FFFF, {16'hFFFF, 16'd3});
		frame_start(32'hFFFF_FFFF, 16'h8000);
		frame_close();
		send_frame();
		set_config(32'h8000_0001, {16'h0000, 16'd16});
		frame_start(32'h8000_0001, 16'h0010);
		frame_close();
		send_frame();
		frame_start(32'h8000_0001, 16'h0011);
		add_chunk(16'h0003, 16'd0);
		frame_close();
		repeat (6) put_byte(8'($urandom));
		send_frame();
		frame_start(32'h8000_0001, 16'h0012);
		add_chunk(16'h0003, 16'd4);
		frame_close();
		send_frame();
	endtask

	task automatic test_random_traffic(input int budget, input int idle_in, input int idle_out,
		input logic [31:0] magic, input logic [31:0] min_word);
		int start;
		set_config(magic, min_word);
		src_idle = idle_in;
		sink_idle = idle_out;
		start = bytes_accepted;
		while (bytes_accepted - start < budget) begin
			build_random_frame();
			send_frame();
		end
	endtask

	// Largest minimum: every frame is too short, including one with the top total length
	task automatic test_large_minimum();
		set_config(32'h5AA5_C33C, {16'h0000, 16'hFFFF});
		frame_start(32'h5AA5_C33C, 16'hFFFF);
		add_chunk(16'hFFFF, 16'd5);
		frame_close();
		send_frame();
		frame_start(32'h5AA5_C33C, 16'hFFFE);
		add_chunk(16'h0001, 16'd2);
		frame_close();
		frame_bytes[6] = 8'hFF;
		frame_bytes[7] = 8'hFF;
		send_frame();
	endtask

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("[tlv_frame_checker] ERROR");
		$finish;
	end

	initial begin
		clear_frame_state();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_status_order();
		test_config_limits();
		test_random_traffic(450, 14, 46, $urandom, {16'($urandom), 16'd10});
		test_random_traffic(450, 46, 14, $urandom,
			{16'($urandom), 16'($urandom_range(11, 40))});
		test_random_traffic(450, 0, 0, 32'h0, {16'($urandom), 16'd4});
		test_large_minimum();
		wait_idle();
		if (fail_count == 0) begin
			$display("[tlv_frame_checker] OK");
		end else begin
			$display("[tlv_frame_checker] ERROR");
		end
		$finish;
	end

endmodule

/* tlv_frame_checker.f */
design/tfc_pkg.sv
design/tlv_frame_checker.sv
tb/testbench.sv
